/* design/upc_pkg.sv */
// Shared types, character constants and helper functions for the URL percent codec.
package upc_pkg;

    // Decode phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;  // nothing pending
    localparam logic [1:0] PH_PCT  = 2'd1;  // '%' pending
    localparam logic [1:0] PH_DIG  = 2'd2;  // '%' and one hex digit pending

    // Mode register values
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Register byte addresses
    localparam logic [0:0] ADDR_MODE = 1'b0;

    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] HI_MASK    = 8'hF0;
    localparam logic [7:0] LO_MASK    = 8'h0F;
    localparam logic [7:0] CASE_MASK  = 8'hDF;
    localparam logic [7:0] ALPHA_BASE = 8'h37;  // 'A' - 10

    localparam int MAX_RESULTS = 3;

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_count;

    // Translation outcome for one input byte
    typedef struct packed {
        t_byte [MAX_RESULTS-1:0] bytes;
        t_count                  count;
        logic [1:0]              phase;
        t_byte                   held;
    } t_xlate;

    function automatic logic is_hex(input t_byte c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [3:0] hex_val(input t_byte c);
        t_byte v;
        if (c >= 8'h41) begin
            v = (c & CASE_MASK) - ALPHA_BASE;
        end else begin
            v = c - 8'h30;
        end
        return v[3:0];
    endfunction

    function automatic t_byte nibble_char(input logic [3:0] n);
        if (n > 4'd9) begin
            return {4'd0, n} + ALPHA_BASE;
        end
        return {4'd0, n} + 8'h30;
    endfunction

    // Letters, digits and the safe punctuation set pass through in encode mode
    function automatic logic passes(input t_byte c);
        return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                          8'h2F, 8'h2B, 8'h2D, 8'h5F, 8'h3F, 8'h24, 8'h40, 8'h27,
                          8'h2A, 8'h28, 8'h29, 8'h3D, 8'h3A, 8'h7E, 8'h7C, 8'h2E,
                          8'h21, 8'h23});
    endfunction

endpackage

/* design/upc_xlate.sv */
// Combinational translation of one input byte into up to three output bytes.
module upc_xlate
    import upc_pkg::*;
(
    input  logic       i_mode,
    input  t_byte      i_char,
    input  logic       i_eos,
    input  logic [1:0] i_phase,
    input  t_byte      i_held,
    output t_xlate     o_res
);

    always_comb begin
        t_byte [MAX_RESULTS-1:0] b;
        t_count     n;
        logic [1:0] ph;
        t_byte      held;
        logic       normal;

        b      = '0;
        n      = '0;
        ph     = PH_IDLE;
        held   = i_held;
        normal = 1'b0;

        if (i_mode == MODE_ENCODE) begin
            // pass through or expand to %XX; pending decode state is dropped
            if (passes(i_char)) begin
                b[0] = i_char;
                n    = 2'd1;
            end else begin
                b[0] = PCT_CHAR;
                b[1] = nibble_char(4'((i_char & HI_MASK) >> 4));
                b[2] = nibble_char(4'(i_char & LO_MASK));
                n    = 2'd3;
            end
        end else begin
            case (i_phase)
                PH_PCT: begin
                    if (is_hex(i_char)) begin
                        held = i_char;
                        ph   = PH_DIG;
                    end else begin
                        b[n]   = PCT_CHAR;
                        n      = n + 2'd1;
                        normal = 1'b1;
                    end
                end
                PH_DIG: begin
                    if (is_hex(i_char)) begin
                        b[n] = {hex_val(i_held), hex_val(i_char)};
                        n    = n + 2'd1;
                    end else begin
                        b[n]        = PCT_CHAR;
                        b[n + 2'd1] = i_held;
                        n           = n + 2'd2;
                        normal      = 1'b1;
                    end
                end
                default: begin
                    normal = 1'b1;
                end
            endcase

            // byte that broke or did not start a sequence
            if (normal) begin
                if (i_char == PCT_CHAR) begin
                    ph = PH_PCT;
                end else begin
                    b[n] = i_char;
                    n    = n + 2'd1;
                end
            end

            // flush whatever is held at end of string
            if (i_eos) begin
                if (ph == PH_PCT) begin
                    b[n] = PCT_CHAR;
                    n    = n + 2'd1;
                end else if (ph == PH_DIG) begin
                    b[n]        = PCT_CHAR;
                    b[n + 2'd1] = held;
                    n           = n + 2'd2;
                end
                ph = PH_IDLE;
            end
        end

        o_res.bytes = b;
        o_res.count = n;
        o_res.phase = ph;
        o_res.held  = held;
    end

endmodule

/* design/url_percent_codec_core.sv */
// Top level of the URL percent encoder/decoder: stream ports, mode register, result buffer.
//
//  Channel | Direction | Payload                                  | Accept
//  s_axis  | in        | tdata=char_in[7:0], tlast=end_of_string  | tvalid & tready
//  m_axis  | out       | tdata=char_out[7:0], tlast=run_last,     | tvalid & tready
//          |           | tuser=string_last                        |
//  apb     | in        | mode at byte address 0                   | psel&penable&pwrite
//
// An input byte is translated in the cycle it is accepted and its 0..3 result
// bytes (three for an escaped byte in encode mode) land in a three-entry result
// buffer, one leaving per cycle while m_axis_tready is high. The next input byte
// is accepted only as the last of them is taken; a result-free byte leaves the buffer empty.
// s_axis_tready is high while the buffer is empty or its last byte is being taken.
// Reset (synchronous) empties the result buffer and clears decode phase, held digit and mode.
module url_percent_codec_core
    import upc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tlast,   // end_of_string
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] char_out
    output logic        m_axis_tlast,   // run_last
    output logic        m_axis_tuser,   // [0] string_last
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       r_mode;
    logic [1:0] r_phase;
    t_byte      r_held;
    t_byte [MAX_RESULTS-1:0] r_buf;
    t_count     r_cnt;
    t_count     r_idx;
    logic       r_eos;

    logic       n_mode;
    logic [1:0] n_phase;
    t_byte      n_held;
    t_count     n_cnt;
    t_count     n_idx;

    t_xlate     xl;
    logic       s_fire;
    logic       m_fire;
    logic       m_last;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MODE) ? {31'd0, r_mode} : 32'd0;

    always_comb begin
        n_mode = r_mode;
        if (psel && penable && pwrite && pready && paddr == ADDR_MODE) begin
            n_mode = pwdata[0];
        end
    end

    // translation of the byte on the input port
    upc_xlate u_xlate (
        .i_mode  (r_mode),
        .i_char  (s_axis_tdata),
        .i_eos   (s_axis_tlast),
        .i_phase (r_phase),
        .i_held  (r_held),
        .o_res   (xl)
    );

    // handshakes
    assign m_last        = (r_idx == r_cnt - 2'd1);
    assign m_fire        = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_cnt == 2'd0) || (m_fire && m_last);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    // output side
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = r_buf[r_idx];
    assign m_axis_tlast  = m_last;
    assign m_axis_tuser  = m_last && r_eos;

    // decode state and result buffer control
    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        if (s_fire) begin
            n_phase = xl.phase;
            n_held  = xl.held;
            n_cnt   = xl.count;
            n_idx   = '0;
        end else if (m_fire) begin
            if (m_last) begin
                n_cnt = '0;
                n_idx = '0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_ENCODE;
            r_phase <= PH_IDLE;
            r_held  <= '0;
            r_cnt   <= '0;
            r_idx   <= '0;
        end else begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_held  <= n_held;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
        end
    end

    // result payload, loaded per accepted byte
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_buf <= xl.bytes;
            r_eos <= s_axis_tlast;
        end
    end

endmodule

/* design/upc_checker.sv */
// Port-level assertions for the URL percent codec, bound to the top level.
module upc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);

    // a stalled output transaction keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
             && $stable(m_axis_tuser)))
        else $error("output payload changed while stalled");

    // end of string is only flagged on the last byte of a run
    a_str_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
        else $error("string_last without run_last");

    // input only stalls while results are pending
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty result buffer");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending after reset");

endmodule

bind url_percent_codec_core upc_checker u_upc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

/* dv/tb_url_percent_codec_core.sv */
// Self-checking testbench for the URL percent codec core: directed and random strings in both modes.
module tb_url_percent_codec_core;
    import upc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One input byte and one expected output byte
    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } src_byte_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       str_last;
    } out_byte_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;    // [7:0] char_in
    logic        s_axis_tlast = 1'b0;    // end_of_string
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // [7:0] char_out
    logic        m_axis_tlast;           // run_last
    logic        m_axis_tuser;           // [0] string_last
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = ADDR_MODE;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Bytes waiting to be sent and output bytes still owed by the block
    src_byte_t   src_q[$];
    out_byte_t   owed_q[$];

    // Shadow of the block's mode register and decoder state
    logic        cfg_mode = MODE_ENCODE;
    logic [1:0]  dec_phase = PH_IDLE;
    logic [7:0]  held_char = 8'd0;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        hold_req = 1'b0;
    logic        hold_used;
    int          hold_cnt;
    int          str_left = 4;
    int          fail_cnt = 0;

    url_percent_codec_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Character classes
    function automatic logic is_hex_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic logic [3:0] hex_weight(input logic [7:0] c);
        logic [7:0] v;
        if (c >= "a") begin
            v = c - "a" + 8'd10;
        end else if (c >= "A") begin
            v = c - "A" + 8'd10;
        end else begin
            v = c - "0";
        end
        return v[3:0];
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'h30 + {4'd0, n};
        end
        return 8'h41 + {4'd0, n} - 8'd10;
    endfunction

    function automatic logic url_safe(input logic [7:0] c);
        if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9")) begin
            return 1'b1;
        end
        case (c)
            "/", "+", "-", "_", "?", "$", "@", "'", "*",
            "(", ")", "=", ":", "~", "|", ".", "!", "#": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Work out the output bytes one accepted input byte owes
    task automatic predict_outputs(input logic [7:0] c, input logic eos);
        logic [7:0] emit [3];
        int         n;
        logic       plain;
        out_byte_t  o;
        n = 0;
        plain = 1'b0;
        if (cfg_mode == MODE_ENCODE) begin
            // encoding drops any half-decoded escape
            dec_phase = PH_IDLE;
            if (url_safe(c)) begin
                emit[0] = c;
                n = 1;
            end else begin
                emit[0] = PCT_CHAR;
                emit[1] = hex_ascii(c[7:4]);
                emit[2] = hex_ascii(c[3:0]);
                n = 3;
            end
        end else begin
            case (dec_phase)
                PH_PCT: begin
                    if (is_hex_char(c)) begin
                        held_char = c;
                        dec_phase = PH_DIG;
                    end else begin
                        emit[n] = PCT_CHAR;
                        n = n + 1;
                        dec_phase = PH_IDLE;
                        plain = 1'b1;
                    end
                end
                PH_DIG: begin
                    if (is_hex_char(c)) begin
                        emit[n] = {hex_weight(held_char), hex_weight(c)};
                        n = n + 1;
                    end else begin
                        emit[n] = PCT_CHAR;
                        emit[n + 1] = held_char;
                        n = n + 2;
                        plain = 1'b1;
                    end
                    dec_phase = PH_IDLE;
                end
                default: begin
                    dec_phase = PH_IDLE;
                    plain = 1'b1;
                end
            endcase
            // byte outside an escape: '%' opens one, anything else passes
            if (plain) begin
                if (c == PCT_CHAR) begin
                    dec_phase = PH_PCT;
                end else begin
                    emit[n] = c;
                    n = n + 1;
                end
            end
            // end of string flushes whatever is held
            if (eos) begin
                if (dec_phase == PH_PCT) begin
                    emit[n] = PCT_CHAR;
                    n = n + 1;
                end else if (dec_phase == PH_DIG) begin
                    emit[n] = PCT_CHAR;
                    emit[n + 1] = held_char;
                    n = n + 2;
                end
                dec_phase = PH_IDLE;
            end
        end
        for (int k = 0; k < n; k++) begin
            o.ch = emit[k];
            o.run_last = (k == n - 1);
            o.str_last = (k == n - 1) && eos;
            owed_q.push_back(o);
        end
    endtask

    // Input driver: offers queued bytes, predicts at each accepted transaction
    always @(posedge i_clk) begin
        logic      busy;
        src_byte_t nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_outputs(s_axis_tdata, s_axis_tlast);
                busy = 1'b0;
            end
            if (!busy) begin
                if (src_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = src_q.pop_front();
                    s_axis_tdata  <= nxt.ch;
                    s_axis_tlast  <= nxt.eos;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here once requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt  <= 0;
            hold_used <= 1'b0;
        end else if (hold_req && !hold_used) begin
            hold_cnt  <= 80;
            hold_used <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Output ready: random stalls, or held low during the hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cnt != 0 || (hold_req && !hold_used)) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: each output transaction against the oldest owed byte
    always @(posedge i_clk) begin
        out_byte_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (owed_q.size() == 0) begin
                $error("unexpected output byte %h", m_axis_tdata);
                fail_cnt++;
            end else begin
                want = owed_q.pop_front();
                if (m_axis_tdata !== want.ch) begin
                    $error("char_out: expected %h, got %h", want.ch, m_axis_tdata);
                    fail_cnt++;
                end
                if (m_axis_tlast !== want.run_last) begin
                    $error("run_last: expected %b, got %b", want.run_last, m_axis_tlast);
                    fail_cnt++;
                end
                if (m_axis_tuser !== want.str_last) begin
                    $error("string_last: expected %b, got %b", want.str_last, m_axis_tuser);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic queue_byte(input logic [7:0] c, input logic eos);
        src_q.push_back('{ch: c, eos: eos});
    endtask

    // Random content with string ends spread at random
    task automatic queue_text_byte(input logic [7:0] c);
        if (str_left <= 1) begin
            queue_byte(c, 1'b1);
            str_left = $urandom_range(12, 1);
        end else begin
            queue_byte(c, 1'b0);
            str_left = str_left - 1;
        end
    endtask

    function automatic logic [7:0] rand_hex_char();
        logic [3:0] n;
        n = 4'($urandom_range(15));
        if (n < 4'd10) begin
            return 8'h30 + {4'd0, n};
        end
        return ($urandom_range(1) ? 8'h61 : 8'h41) + {4'd0, n} - 8'd10;
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (is_hex_char(c));
        return c;
    endfunction

    task automatic queue_encode_text(input int count);
        for (int k = 0; k < count; k++) begin
            queue_text_byte(8'($urandom_range(255)));
        end
    endtask

    // Mostly well-formed escapes, with broken ones and raw bytes mixed in
    task automatic queue_decode_text(input int count);
        int before_cnt;
        before_cnt = src_q.size();
        while (src_q.size() - before_cnt < count) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    queue_text_byte(PCT_CHAR);
                    queue_text_byte(rand_hex_char());
                    queue_text_byte(rand_hex_char());
                end
                4: begin
                    queue_text_byte(PCT_CHAR);
                    queue_text_byte(rand_non_hex());
                end
                5: begin
                    queue_text_byte(PCT_CHAR);
                    queue_text_byte(rand_hex_char());
                    queue_text_byte(rand_non_hex());
                end
                6: begin
                    queue_text_byte(PCT_CHAR);
                    queue_text_byte(PCT_CHAR);
                end
                7, 8: queue_text_byte(8'($urandom_range(255)));
                default: queue_text_byte(rand_hex_char());
            endcase
        end
    endtask

    task automatic set_profile(input int send_pct, input int recv_pct);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Wait for the block to drain, then let a result-free byte finish;
    // sampled on the falling edge so driver and monitor updates have settled
    task automatic wait_drained();
        while (src_q.size() != 0 || s_axis_tvalid || owed_q.size() != 0 ||
               m_axis_tvalid) begin
            @(negedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    // Register write and read-back through the APB port
    task automatic set_mode(input logic m);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MODE;
        pwdata  <= {31'd0, m};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        cfg_mode = m;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {31'd0, m}) begin
            $error("mode readback: expected %h, got %h", {31'd0, m}, prdata);
            fail_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stimulus sequence
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // encode, directed: range ends, safe and unsafe bytes
        set_mode(MODE_ENCODE);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte("A", 1'b0);
        queue_byte("9", 1'b0);
        queue_byte("~", 1'b0);
        queue_byte("#", 1'b0);
        queue_byte(PCT_CHAR, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(" ", 1'b1);
        wait_drained();

        // decode, directed: both digit cases, broken escapes, flush at end
        set_mode(MODE_DECODE);
        queue_byte(PCT_CHAR, 1'b0);
        queue_byte("4", 1'b0);
        queue_byte("a", 1'b0);
        queue_byte(PCT_CHAR, 1'b0);
        queue_byte(PCT_CHAR, 1'b0);
        queue_byte("3", 1'b0);
        queue_byte("F", 1'b0);
        queue_byte(PCT_CHAR, 1'b0);
        queue_byte("g", 1'b0);
        queue_byte(PCT_CHAR, 1'b0);
        queue_byte("4", 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(PCT_CHAR, 1'b1);
        queue_byte(PCT_CHAR, 1'b0);
        queue_byte("7", 1'b1);
        // leave an escape half done for the mode switch below
        queue_byte(PCT_CHAR, 1'b0);
        queue_byte("C", 1'b0);
        wait_drained();

        // encode with a long output hold-off while input keeps coming
        set_mode(MODE_ENCODE);
        hold_req <= 1'b1;
        queue_encode_text(42);
        wait_drained();

        set_mode(MODE_DECODE);
        set_profile(68, 0);
        queue_decode_text(42);
        wait_drained();

        set_mode(MODE_ENCODE);
        set_profile(0, 68);
        queue_encode_text(42);
        wait_drained();

        set_mode(MODE_DECODE);
        set_profile(37, 37);
        queue_decode_text(42);
        wait_drained();

        set_mode(MODE_DECODE);
        set_profile(0, 0);
        queue_decode_text(42);
        wait_drained();

        set_mode(MODE_ENCODE);
        set_profile(37, 37);
        queue_encode_text(42);
        wait_drained();

        if (fail_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
